[hdl/iir_df1_pkg.sv]
// Shared types, widths and command codes for the direct form I IIR filter.
package iir_df1_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int COEF_WIDTH     = 24;
    localparam int COEF_FRAC      = COEF_WIDTH - 4;
    localparam int ORDER_WIDTH    = 4;
    localparam int INDEX_WIDTH    = 4;
    localparam int PROD_WIDTH     = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int CFG_DATA_WIDTH = ORDER_WIDTH;

    typedef enum logic [1:0] {
        MODE_SAMPLE     = 2'd0,
        MODE_FLUSH      = 2'd1,
        MODE_WRITE_POLE = 2'd2,
        MODE_WRITE_ZERO = 2'd3
    } iir_mode_t;

    typedef enum logic [0:0] {
        REG_POLE_ORDER = 1'b0,
        REG_ZERO_ORDER = 1'b1
    } iir_reg_t;

    typedef struct packed {
        iir_mode_t                      mode;
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic [INDEX_WIDTH-1:0]         coef_index;
        logic signed [COEF_WIDTH-1:0]   coef_value;
        logic                           end_of_frame;
    } iir_in_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] out_sample;
        logic                           clipped;
        logic                           last;
        logic                           end_of_frame_out;
    } iir_out_t;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic shift_in;    // push a new sample into the input history
        logic shift_zero;  // push zero instead of the beat's sample
        logic clear_acc;
        logic rot_zero;    // rotate input history and zero coefficients one place
        logic rot_pole;    // rotate output history and pole coefficients one place
        logic mac_en;      // accumulate the current product
        logic mac_pole;    // product is a feedback term, subtract it
        logic wr_pole;
        logic wr_zero;
        logic finish;      // round, saturate, load result, push output history
        logic out_last;
        logic out_eof;
    } iir_cmd_t;

endpackage

[hdl/iir_df1_ctrl.sv]
// Sequencer for the direct form I IIR filter: handshakes, orders and tap stepping.
module iir_df1_ctrl #(
    parameter int MAX_POLES = 8,
    parameter int MAX_ZEROS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  iir_df1_pkg::iir_in_t                  in_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic                                  cfg_wr_en,
    input  logic [0:0]                            cfg_index,
    input  logic [iir_df1_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
    output iir_df1_pkg::iir_cmd_t                 cmd
);
    import iir_df1_pkg::*;

    localparam int MAX_TAPS = (MAX_ZEROS > MAX_POLES) ? MAX_ZEROS : MAX_POLES;
    localparam int CNT_W    = $clog2(MAX_TAPS + 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_ZMAC   = 5'b00010,
        S_PMAC   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       step_reg, step_next;
    logic [CNT_W-1:0]       left_reg, left_next;
    logic                   flush_reg, flush_next;
    logic                   eof_reg, eof_next;
    logic                   out_valid_reg, out_valid_next;
    logic [ORDER_WIDTH-1:0] pole_order_reg, zero_order_reg;
    logic [CNT_W-1:0]       n_eff, m_eff;
    logic                   out_free;

    // Clamp orders to the built depth
    assign n_eff = (zero_order_reg > MAX_ZEROS) ? CNT_W'(MAX_ZEROS) : CNT_W'(zero_order_reg);
    assign m_eff = (pole_order_reg > MAX_POLES) ? CNT_W'(MAX_POLES) : CNT_W'(pole_order_reg);

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pole_order_reg <= '0;
            zero_order_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_POLE_ORDER: pole_order_reg <= cfg_data;
                REG_ZERO_ORDER: zero_order_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        left_next      = left_reg;
        flush_next     = flush_reg;
        eof_next       = eof_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_data.mode)
                        MODE_SAMPLE:
                        begin
                            cmd.shift_in  = 1'b1;
                            cmd.clear_acc = 1'b1;
                            flush_next    = 1'b0;
                            eof_next      = in_data.end_of_frame;
                            step_next     = '0;
                            state_next    = S_ZMAC;
                        end
                        MODE_FLUSH:
                        begin
                            if (n_eff != '0)
                            begin
                                cmd.shift_in   = 1'b1;
                                cmd.shift_zero = 1'b1;
                                cmd.clear_acc  = 1'b1;
                                flush_next     = 1'b1;
                                eof_next       = 1'b0;
                                left_next      = n_eff;
                                step_next      = '0;
                                state_next     = S_ZMAC;
                            end
                        end
                        MODE_WRITE_POLE: cmd.wr_pole = 1'b1;
                        MODE_WRITE_ZERO: cmd.wr_zero = 1'b1;
                        default:         ;
                    endcase
                end
            end
            S_ZMAC:
            begin
                cmd.rot_zero = 1'b1;
                cmd.mac_en   = (step_reg <= n_eff);
                if (step_reg == CNT_W'(MAX_ZEROS))
                begin
                    step_next  = '0;
                    state_next = S_PMAC;
                end
                else
                begin
                    step_next = step_reg + CNT_W'(1);
                end
            end
            S_PMAC:
            begin
                cmd.rot_pole = 1'b1;
                cmd.mac_pole = 1'b1;
                cmd.mac_en   = (step_reg < m_eff);
                if (step_reg == CNT_W'(MAX_POLES - 1))
                begin
                    step_next  = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    step_next = step_reg + CNT_W'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // Hold until the result register can take the beat
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    cmd.out_last   = !flush_reg || (left_reg == CNT_W'(1));
                    cmd.out_eof    = eof_reg;
                    out_valid_next = 1'b1;
                    if (flush_reg && (left_reg != CNT_W'(1)))
                    begin
                        cmd.shift_in   = 1'b1;
                        cmd.shift_zero = 1'b1;
                        cmd.clear_acc  = 1'b1;
                        left_next      = left_reg - CNT_W'(1);
                        step_next      = '0;
                        state_next     = S_ZMAC;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            left_reg      <= '0;
            flush_reg     <= 1'b0;
            eof_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            left_reg      <= left_next;
            flush_reg     <= flush_next;
            eof_reg       <= eof_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hdl/iir_df1_datapath.sv]
// Datapath for the direct form I IIR filter: tap stores, shared MAC, rounding and result register.
module iir_df1_datapath #(
    parameter int MAX_POLES = 8,
    parameter int MAX_ZEROS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  iir_df1_pkg::iir_in_t   in_data,
    input  iir_df1_pkg::iir_cmd_t  cmd,
    output iir_df1_pkg::iir_out_t  out_data
);
    import iir_df1_pkg::*;

    localparam int ZD    = MAX_ZEROS + 1;
    localparam int PD    = MAX_POLES;
    localparam int ACC_W = PROD_WIDTH + $clog2(MAX_ZEROS + MAX_POLES + 1) + 1;
    localparam int Y_W   = ACC_W - COEF_FRAC;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (COEF_FRAC - 1));
    localparam logic signed [Y_W-1:0]   SAT_MAX    = Y_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [Y_W-1:0]   SAT_MIN    = ~SAT_MAX;

    logic signed [SAMPLE_WIDTH-1:0] in_hist_reg  [ZD];
    logic signed [COEF_WIDTH-1:0]   zero_coef_reg[ZD];
    logic signed [SAMPLE_WIDTH-1:0] out_hist_reg [PD];
    logic signed [COEF_WIDTH-1:0]   pole_coef_reg[PD];

    logic signed [PROD_WIDTH-1:0]   prod_reg;
    logic                           add_reg;
    logic                           sub_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    iir_out_t                       out_reg;

    logic signed [SAMPLE_WIDTH-1:0] mul_x;
    logic signed [COEF_WIDTH-1:0]   mul_c;
    logic signed [SAMPLE_WIDTH-1:0] new_x;
    logic signed [ACC_W-1:0]        prod_ext;
    logic signed [ACC_W-1:0]        rounded;
    logic signed [Y_W-1:0]          y_full;
    logic signed [SAMPLE_WIDTH-1:0] y_sat;
    logic                           y_clip;

    assign new_x = cmd.shift_zero ? '0 : in_data.sample;

    // Input history: push on a new sample, rotate during the feedforward sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ZD; i++)
                in_hist_reg[i] <= '0;
        end
        else if (cmd.shift_in)
        begin
            in_hist_reg[0] <= new_x;
            for (int i = 1; i < ZD; i++)
                in_hist_reg[i] <= in_hist_reg[i-1];
        end
        else if (cmd.rot_zero)
        begin
            for (int i = 0; i < ZD - 1; i++)
                in_hist_reg[i] <= in_hist_reg[i+1];
            in_hist_reg[ZD-1] <= in_hist_reg[0];
        end
    end

    // Feedforward coefficients: load one, rotate with the input history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ZD; i++)
                zero_coef_reg[i] <= '0;
        end
        else if (cmd.wr_zero)
        begin
            for (int i = 0; i < ZD; i++)
                if (in_data.coef_index == i)
                    zero_coef_reg[i] <= in_data.coef_value;
        end
        else if (cmd.rot_zero)
        begin
            for (int i = 0; i < ZD - 1; i++)
                zero_coef_reg[i] <= zero_coef_reg[i+1];
            zero_coef_reg[ZD-1] <= zero_coef_reg[0];
        end
    end

    // Output history: push the saturated result, rotate during the feedback sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PD; i++)
                out_hist_reg[i] <= '0;
        end
        else if (cmd.finish)
        begin
            out_hist_reg[0] <= y_sat;
            for (int i = 1; i < PD; i++)
                out_hist_reg[i] <= out_hist_reg[i-1];
        end
        else if (cmd.rot_pole)
        begin
            for (int i = 0; i < PD - 1; i++)
                out_hist_reg[i] <= out_hist_reg[i+1];
            out_hist_reg[PD-1] <= out_hist_reg[0];
        end
    end

    // Feedback coefficients: a1 sits in entry zero, index zero is never written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PD; i++)
                pole_coef_reg[i] <= '0;
        end
        else if (cmd.wr_pole)
        begin
            for (int i = 0; i < PD; i++)
                if (in_data.coef_index == i + 1)
                    pole_coef_reg[i] <= in_data.coef_value;
        end
        else if (cmd.rot_pole)
        begin
            for (int i = 0; i < PD - 1; i++)
                pole_coef_reg[i] <= pole_coef_reg[i+1];
            pole_coef_reg[PD-1] <= pole_coef_reg[0];
        end
    end

    // Shared multiplier on the head of whichever store is sweeping
    assign mul_x = cmd.mac_pole ? out_hist_reg[0]  : in_hist_reg[0];
    assign mul_c = cmd.mac_pole ? pole_coef_reg[0] : zero_coef_reg[0];

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_WIDTH'(mul_x * mul_c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            add_reg <= 1'b0;
            sub_reg <= 1'b0;
        end
        else
        begin
            add_reg <= cmd.mac_en;
            sub_reg <= cmd.mac_pole;
        end
    end

    // Accumulate exactly: feedforward terms add, feedback terms subtract
    assign prod_ext = ACC_W'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.clear_acc)
            acc_reg <= '0;
        else if (add_reg)
            acc_reg <= sub_reg ? (acc_reg - prod_ext) : (acc_reg + prod_ext);
    end

    // Round to nearest, ties up, then saturate to the sample width
    assign rounded = acc_reg + ROUND_HALF;
    assign y_full  = Y_W'(rounded >>> COEF_FRAC);

    always_comb
    begin
        if (y_full > SAT_MAX)
        begin
            y_sat  = SAT_MAX[SAMPLE_WIDTH-1:0];
            y_clip = 1'b1;
        end
        else if (y_full < SAT_MIN)
        begin
            y_sat  = SAT_MIN[SAMPLE_WIDTH-1:0];
            y_clip = 1'b1;
        end
        else
        begin
            y_sat  = y_full[SAMPLE_WIDTH-1:0];
            y_clip = 1'b0;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_reg.out_sample       <= y_sat;
            out_reg.clipped          <= y_clip;
            out_reg.last             <= cmd.out_last;
            out_reg.end_of_frame_out <= cmd.out_eof;
        end
    end

    assign out_data = out_reg;

endmodule

[hdl/iir_direct_form_one_filter_unit.sv]
// Direct form I IIR filter, top level: sequencer plus datapath with one shared MAC.
// An accepted sample beat is swept through S_ZMAC, S_PMAC and S_DRAIN, then S_FINISH loads its result.
// Samples do not overlap: in_stall holds off the next beat until the result is loaded, as the single
// multiplier sweeps all feedforward then all feedback taps; a flush repeats the sweep for each result.
// Coefficient writes leave the sequencer idle; a finished result waits in its register.
// Reset (rst_n, asynchronous): histories, coefficients and orders clear to zero.
module iir_direct_form_one_filter_unit #(
    parameter int MAX_POLES = 8,
    parameter int MAX_ZEROS = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  iir_df1_pkg::iir_in_t                   in_data,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output iir_df1_pkg::iir_out_t                  out_data,
    input  logic                                   cfg_wr_en,
    input  logic [0:0]                             cfg_index,
    input  logic [iir_df1_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);
    import iir_df1_pkg::*;

    iir_cmd_t cmd;

    iir_df1_ctrl #(
        .MAX_POLES (MAX_POLES),
        .MAX_ZEROS (MAX_ZEROS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd)
    );

    iir_df1_datapath #(
        .MAX_POLES (MAX_POLES),
        .MAX_ZEROS (MAX_ZEROS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .out_data (out_data)
    );

    // A new result never overwrites one still waiting downstream
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid || !out_stall))
        else $error("result loaded over a stalled beat");

    // A sample beat makes the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (in_data.mode == MODE_SAMPLE)) |=> in_stall)
        else $error("sample beat did not start a sweep");

    // History push and tap rotation never coincide
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.shift_in && (cmd.rot_zero || cmd.rot_pole)))
        else $error("history push during tap sweep");

    // Products are only accumulated during a sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mac_en |-> (cmd.rot_zero || cmd.rot_pole))
        else $error("accumulate outside a sweep");

endmodule
